// ----- hw/rtl/rast_pkg.sv -----
`timescale 1ns / 1ps
// Package for the range add / range sum core.
// Holds the shared widths, command codes and sequencer state type; depends on nothing.
package rast_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int WALK_W       = ADDR_W + 2;
    localparam int DATA_W       = 64;
    localparam int CMD_W        = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRE_RD,
        S_PRE_ACC,
        S_PRE_MUL,
        S_PRE_FIN,
        S_UPD_MUL,
        S_UPD_RD,
        S_UPD_WR,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/range_add_range_sum_tree_core.sv -----
`timescale 1ns / 1ps
// Top level of the range add / range sum core: sequencer and arithmetic around two tree stores.
// Depends on rast_pkg and rast_ram.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_cmd, i_lo, i_hi, i_value
//  out     | output    | o_out_valid/i_out_stall | o_range_sum
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (element count)
//
// Each tree walk step is a registered RAM read, then a write or accumulate.
// A load runs the prefix walks of a query and then the walks of an add;
// the walk length follows the bit pattern of the index.
// After reset and after every count write a clearing pass over all 1024 entries runs,
// during which no transaction is accepted on the input channel.
// One transaction is worked at a time; a result held by i_out_stall holds the core.
module range_add_range_sum_tree_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rast_pkg::CMD_W-1:0]  i_cmd,
    input  logic [rast_pkg::ADDR_W-1:0] i_lo,
    input  logic [rast_pkg::ADDR_W-1:0] i_hi,
    input  logic signed [63:0]          i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [63:0]          o_range_sum,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rast_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam logic [rast_pkg::CNT_W-1:0] MaxCnt = rast_pkg::CNT_W'(rast_pkg::MAX_ELEMENTS);
    localparam logic [rast_pkg::ADDR_W-1:0] LastAddr =
        rast_pkg::ADDR_W'(rast_pkg::MAX_ELEMENTS - 1);

    rast_pkg::t_state r_state, n_state;
    logic [rast_pkg::CNT_W-1:0]  r_count, n_count;
    logic [rast_pkg::ADDR_W-1:0] r_clr, n_clr;
    logic [rast_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [rast_pkg::ADDR_W-1:0] r_lo, n_lo;
    logic [rast_pkg::ADDR_W-1:0] r_hi, n_hi;
    logic [63:0]                 r_val, n_val;
    logic                        r_phase, n_phase;
    logic [rast_pkg::WALK_W-1:0] r_idx, n_idx;
    logic [rast_pkg::CNT_W-1:0]  r_px, n_px;
    logic [63:0]                 r_acc1, n_acc1;
    logic [63:0]                 r_acc2, n_acc2;
    logic [63:0]                 r_prod, n_prod;
    logic [63:0]                 r_res, n_res;
    logic [63:0]                 r_d1, n_d1;
    logic [63:0]                 r_d2, n_d2;

    logic                        mem_wr_en;
    logic                        mem_rd_en;
    logic [rast_pkg::ADDR_W-1:0] mem_addr;
    logic [63:0]                 wr_data1, wr_data2;
    logic [63:0]                 rd_data1, rd_data2;

    logic [rast_pkg::CNT_W-1:0]  used_cnt;
    logic [rast_pkg::ADDR_W-1:0] last_idx;
    logic [rast_pkg::ADDR_W-1:0] lo_clip, hi_clip;
    logic [rast_pkg::WALK_W-1:0] idx_m1;
    logic [rast_pkg::WALK_W-1:0] low_bit;
    logic [rast_pkg::CNT_W-1:0]  upd_pos;
    logic [63:0]                 upd_delta;
    logic [63:0]                 pre_val;
    logic [63:0]                 pre_fin;
    logic                        in_acc;
    logic                        cfg_acc;

    rast_ram #(.WIDTH(64), .DEPTH(rast_pkg::MAX_ELEMENTS)) u_ram_b1 (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_addr),
        .i_wr_data(wr_data1),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_addr),
        .o_rd_data(rd_data1)
    );

    rast_ram #(.WIDTH(64), .DEPTH(rast_pkg::MAX_ELEMENTS)) u_ram_b2 (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_addr),
        .i_wr_data(wr_data2),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_addr),
        .o_rd_data(rd_data2)
    );

    assign o_in_stall  = (r_state != rast_pkg::S_IDLE);
    assign o_out_valid = (r_state == rast_pkg::S_OUT);
    assign o_range_sum = r_res;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (r_count == '0) begin
            used_cnt = rast_pkg::CNT_W'(1);
        end else if (r_count > MaxCnt) begin
            used_cnt = MaxCnt;
        end else begin
            used_cnt = r_count;
        end
    end

    assign last_idx  = rast_pkg::ADDR_W'(used_cnt - rast_pkg::CNT_W'(1));
    assign lo_clip   = (i_lo > last_idx) ? last_idx : i_lo;
    assign hi_clip   = (i_hi > last_idx) ? last_idx : i_hi;
    assign idx_m1    = r_idx - rast_pkg::WALK_W'(1);
    assign low_bit   = r_idx & (~r_idx + rast_pkg::WALK_W'(1));
    assign upd_pos   = r_phase ? ({1'b0, r_hi} + rast_pkg::CNT_W'(1)) : {1'b0, r_lo};
    assign upd_delta = r_phase ? (64'd0 - r_val) : r_val;
    assign pre_val   = r_prod - r_acc2;
    assign pre_fin   = r_phase ? (r_res - pre_val) : pre_val;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_clr     = r_clr;
        n_cmd     = r_cmd;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_val     = r_val;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_px      = r_px;
        n_acc1    = r_acc1;
        n_acc2    = r_acc2;
        n_prod    = r_prod;
        n_res     = r_res;
        n_d1      = r_d1;
        n_d2      = r_d2;
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
        mem_addr  = idx_m1[rast_pkg::ADDR_W-1:0];
        wr_data1  = rd_data1 + r_d1;
        wr_data2  = rd_data2 + r_d2;

        case (r_state)
            rast_pkg::S_CLEAR: begin
                mem_wr_en = 1'b1;
                mem_addr  = r_clr;
                wr_data1  = '0;
                wr_data2  = '0;
                n_clr     = r_clr + rast_pkg::ADDR_W'(1);
                if (r_clr == LastAddr) begin
                    n_state = rast_pkg::S_IDLE;
                end
            end
            rast_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_cmd;
                    n_lo    = lo_clip;
                    n_hi    = hi_clip;
                    n_val   = i_value;
                    n_phase = 1'b0;
                    n_acc1  = '0;
                    n_acc2  = '0;
                    case (i_cmd)
                        rast_pkg::CMD_LOAD: begin
                            n_hi    = lo_clip;
                            n_idx   = {2'b00, lo_clip} + rast_pkg::WALK_W'(1);
                            n_px    = {1'b0, lo_clip} + rast_pkg::CNT_W'(1);
                            n_state = rast_pkg::S_PRE_RD;
                        end
                        rast_pkg::CMD_ADD: begin
                            if (lo_clip <= hi_clip) begin
                                n_state = rast_pkg::S_UPD_MUL;
                            end
                        end
                        rast_pkg::CMD_QUERY: begin
                            if (lo_clip <= hi_clip) begin
                                n_idx   = {2'b00, hi_clip} + rast_pkg::WALK_W'(1);
                                n_px    = {1'b0, hi_clip} + rast_pkg::CNT_W'(1);
                                n_state = rast_pkg::S_PRE_RD;
                            end else begin
                                n_res   = '0;
                                n_state = rast_pkg::S_OUT;
                            end
                        end
                        default: begin
                            n_state = rast_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            rast_pkg::S_PRE_RD: begin
                mem_rd_en = 1'b1;
                n_state   = rast_pkg::S_PRE_ACC;
            end
            rast_pkg::S_PRE_ACC: begin
                n_acc1 = r_acc1 + rd_data1;
                n_acc2 = r_acc2 + rd_data2;
                n_idx  = r_idx - low_bit;
                if ((r_idx - low_bit) == '0) begin
                    n_state = rast_pkg::S_PRE_MUL;
                end else begin
                    n_state = rast_pkg::S_PRE_RD;
                end
            end
            rast_pkg::S_PRE_MUL: begin
                n_prod  = r_acc1 * {{(64 - rast_pkg::CNT_W){1'b0}}, r_px};
                n_state = rast_pkg::S_PRE_FIN;
            end
            rast_pkg::S_PRE_FIN: begin
                n_res = pre_fin;
                if (!r_phase && (r_lo != '0)) begin
                    n_phase = 1'b1;
                    n_idx   = {2'b00, r_lo};
                    n_px    = {1'b0, r_lo};
                    n_acc1  = '0;
                    n_acc2  = '0;
                    n_state = rast_pkg::S_PRE_RD;
                end else if (r_cmd == rast_pkg::CMD_QUERY) begin
                    n_state = rast_pkg::S_OUT;
                end else begin
                    n_val   = r_val - pre_fin;
                    n_phase = 1'b0;
                    n_state = rast_pkg::S_UPD_MUL;
                end
            end
            rast_pkg::S_UPD_MUL: begin
                n_d1    = upd_delta;
                n_d2    = upd_delta * {{(64 - rast_pkg::CNT_W){1'b0}}, upd_pos};
                n_idx   = {1'b0, upd_pos} + rast_pkg::WALK_W'(1);
                n_state = rast_pkg::S_UPD_RD;
            end
            rast_pkg::S_UPD_RD: begin
                mem_rd_en = 1'b1;
                n_state   = rast_pkg::S_UPD_WR;
            end
            rast_pkg::S_UPD_WR: begin
                mem_wr_en = 1'b1;
                n_idx     = r_idx + low_bit;
                if ((r_idx + low_bit) > rast_pkg::WALK_W'(rast_pkg::MAX_ELEMENTS)) begin
                    if (!r_phase && (r_hi != LastAddr)) begin
                        n_phase = 1'b1;
                        n_state = rast_pkg::S_UPD_MUL;
                    end else begin
                        n_state = rast_pkg::S_IDLE;
                    end
                end else begin
                    n_state = rast_pkg::S_UPD_RD;
                end
            end
            rast_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = rast_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rast_pkg::S_CLEAR;
                n_clr   = '0;
            end
        endcase

        if (cfg_acc) begin
            n_count = i_cfg_data;
            n_clr   = '0;
            n_state = rast_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rast_pkg::S_CLEAR;
            r_count <= MaxCnt;
            r_clr   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_clr   <= n_clr;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_px   <= n_px;
        r_acc1 <= n_acc1;
        r_acc2 <= n_acc2;
        r_prod <= n_prod;
        r_res  <= n_res;
        r_d1   <= n_d1;
        r_d2   <= n_d2;
    end

endmodule

// ----- hw/rtl/rast_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for both coefficient stores of the core.
module rast_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/rast_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the range add / range sum core, bound to its top level.
// Depends on range_add_range_sum_tree_core and rast_pkg.
module rast_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [rast_pkg::CMD_W-1:0]  i_cmd,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic signed [63:0]          o_range_sum,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_range_sum))
        else $error("Stalled result transaction changed or dropped.");

    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input accepted while a result transaction is pending.");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_cmd == rast_pkg::CMD_QUERY) |=> o_in_stall)
        else $error("Query transaction did not occupy the core.");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> o_in_stall && !o_out_valid)
        else $error("Count write did not start the clearing pass.");

endmodule

bind range_add_range_sum_tree_core rast_checker u_rast_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_cmd      (i_cmd),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_range_sum(o_range_sum),
    .i_cfg_valid(i_cfg_valid),
    .o_cfg_ready(o_cfg_ready)
);

// ----- tb/tb_range_add_range_sum_tree_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for range_add_range_sum_tree_core: directed table, then random traffic
// over several element counts, checked against a flat array model. Depends on rast_pkg.
module tb_range_add_range_sum_tree_core;

    typedef struct {
        logic [rast_pkg::CMD_W-1:0]  cmd;
        logic [rast_pkg::ADDR_W-1:0] lo;
        logic [rast_pkg::ADDR_W-1:0] hi;
        logic [63:0]                 value;
        bit                          fixed;
        logic [63:0]                 fixed_sum;
    } t_row;

    localparam logic [rast_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
    localparam int DRAIN_CYCLES = 200;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [rast_pkg::CMD_W-1:0]    cmd;
    logic [rast_pkg::ADDR_W-1:0]   lo;
    logic [rast_pkg::ADDR_W-1:0]   hi;
    logic signed [63:0]            value;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [63:0]            range_sum;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rast_pkg::CNT_W-1:0]    cfg_data;

    logic [63:0] elements [rast_pkg::MAX_ELEMENTS];
    int          used_n;
    logic [63:0] pending_sums [$];
    int          fail_count;
    int          item_count;
    int          sum_count;
    int          stall_left;
    bit          quiet;

    range_add_range_sum_tree_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_cmd(cmd), .i_lo(lo), .i_hi(hi), .i_value(value),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_range_sum(range_sum),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("** range_add_range_sum_tree_core: FAILED **");
        $finish;
    end

    function automatic void clear_elements(int count);
        for (int i = 0; i < rast_pkg::MAX_ELEMENTS; i++) elements[i] = '0;
        used_n = (count < 1) ? 1 :
                 (count > rast_pkg::MAX_ELEMENTS) ? rast_pkg::MAX_ELEMENTS : count;
    endfunction

    // Applies one transaction to the array and returns 1 with the sum if it yields a result.
    function automatic bit apply_command(logic [rast_pkg::CMD_W-1:0] c, int l, int h,
                                         logic [63:0] v, output logic [63:0] sum);
        int last;
        last = used_n - 1;
        sum = '0;
        if (l > last) l = last;
        if (h > last) h = last;
        case (c)
            rast_pkg::CMD_LOAD: begin
                elements[l] = v;
                return 1'b0;
            end
            rast_pkg::CMD_ADD: begin
                for (int i = l; i <= h; i++) elements[i] = elements[i] + v;
                return 1'b0;
            end
            rast_pkg::CMD_QUERY: begin
                for (int i = l; i <= h; i++) sum = sum + elements[i];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic send_item(t_row row);
        logic [63:0] sum;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= row.cmd;
        lo       <= row.lo;
        hi       <= row.hi;
        value    <= row.value;
        do @(posedge clk); while (in_stall);
        item_count++;
        if (apply_command(row.cmd, int'(row.lo), int'(row.hi), row.value, sum))
            pending_sums.push_back(row.fixed ? row.fixed_sum : sum);
    endtask

    task automatic write_count(logic [rast_pkg::CNT_W-1:0] count);
        in_valid <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        clear_elements(int'(count));
    endtask

    function automatic t_row random_row();
        t_row r;
        int pick;
        pick = $urandom_range(0, 99);
        r.cmd = (pick < 30) ? rast_pkg::CMD_LOAD : (pick < 60) ? rast_pkg::CMD_ADD :
                (pick < 95) ? rast_pkg::CMD_QUERY : CMD_UNUSED;
        if ($urandom_range(0, 9) == 0) begin
            r.lo = rast_pkg::ADDR_W'($urandom);
            r.hi = rast_pkg::ADDR_W'($urandom);
        end else begin
            r.lo = rast_pkg::ADDR_W'($urandom_range(0, used_n - 1));
            r.hi = rast_pkg::ADDR_W'($urandom_range(r.lo, used_n - 1));
            if ($urandom_range(0, 9) == 0) r.hi = rast_pkg::ADDR_W'($urandom_range(0, r.lo));
        end
        r.value = ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                               : 64'($signed($urandom_range(0, 200)) - 100);
        r.fixed = 1'b0;
        r.fixed_sum = '0;
        return r;
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_sums.size() == 0) begin
                    $error("range_sum: no result expected, got %0d", range_sum);
                    fail_count++;
                end else begin
                    if (range_sum !== pending_sums[0]) begin
                        $error("range_sum: expected %0d, got %0d",
                               $signed(pending_sums[0]), range_sum);
                        fail_count++;
                    end
                    void'(pending_sums.pop_front());
                    sum_count++;
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left <= $urandom_range(0, 3);
                out_stall  <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_row directed [] = '{
            '{rast_pkg::CMD_QUERY, 10'd0,    10'd1023, 64'd0,   1'b1, 64'd0},
            '{rast_pkg::CMD_LOAD,  10'd0,    10'd0,    MAX_POS, 1'b0, 64'd0},
            '{rast_pkg::CMD_LOAD,  10'd1023, 10'd0,    MIN_NEG, 1'b0, 64'd0},
            '{rast_pkg::CMD_QUERY, 10'd0,    10'd1023, 64'd0,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            '{rast_pkg::CMD_QUERY, 10'd1023, 10'd1023, 64'd0,   1'b1, MIN_NEG},
            '{rast_pkg::CMD_QUERY, 10'd5,    10'd4,    64'd0,   1'b1, 64'd0},
            '{CMD_UNUSED,          10'd0,    10'd1023, MAX_POS, 1'b0, 64'd0},
            '{rast_pkg::CMD_ADD,   10'd0,    10'd1023, 64'd1,   1'b0, 64'd0},
            '{rast_pkg::CMD_ADD,   10'd700,  10'd3,    64'd9,   1'b0, 64'd0},
            '{rast_pkg::CMD_QUERY, 10'd0,    10'd1023, 64'd0,   1'b0, 64'd0},
            '{rast_pkg::CMD_ADD,   10'd3,    10'd517,  MIN_NEG, 1'b0, 64'd0},
            '{rast_pkg::CMD_LOAD,  10'd511,  10'd0,    64'd77,  1'b0, 64'd0},
            '{rast_pkg::CMD_QUERY, 10'd1,    10'd1022, 64'd0,   1'b0, 64'd0},
            '{rast_pkg::CMD_QUERY, 10'd511,  10'd512,  64'd0,   1'b0, 64'd0},
            '{rast_pkg::CMD_QUERY, 10'd0,    10'd0,    64'd0,   1'b0, 64'd0}
        };
        logic [rast_pkg::CNT_W-1:0] counts [] = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd5,
                                                  11'd100, 11'd37, 11'd1000, 11'd1024};
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = rast_pkg::CMD_LOAD;
        lo         = '0;
        hi         = '0;
        value      = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        fail_count = 0;
        item_count = 0;
        sum_count  = 0;
        quiet      = 1'b0;
        clear_elements(rast_pkg::MAX_ELEMENTS);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) send_item(directed[i]);
        foreach (counts[p]) begin
            write_count(counts[p]);
            if (p == counts.size() - 1) quiet = 1'b1;
            repeat (165) send_item(random_row());
        end

        in_valid <= 1'b0;
        wait (pending_sums.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d transactions over %0d element counts; checked %0d range sums.",
                 item_count, counts.size() + 1, sum_count);
        if (fail_count == 0) begin
            $display("** range_add_range_sum_tree_core: PASSED **");
        end else begin
            $display("** range_add_range_sum_tree_core: FAILED **");
        end
        $finish;
    end

endmodule
